// File: rtl/dma_channel_sequencer_defines.svh
// Assertion macros for the DMA channel sequencer.
// No dependencies.
`ifndef DMA_CHANNEL_SEQUENCER_DEFINES_SVH
`define DMA_CHANNEL_SEQUENCER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DCS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DCS_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DCS_ASSERT(label, clk, rst, prop, msg)
`define DCS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// File: rtl/dcs_pkg.sv
// Shared types and constants for the DMA channel sequencer.
// No dependencies.
package dcs_pkg;
   localparam int MaxPackets = 50000;

   localparam logic [2:0] KIND_START = 3'd0;
   localparam logic [2:0] KIND_MEM   = 3'd1;
   localparam logic [2:0] KIND_DEV   = 3'd2;
   localparam logic [2:0] KIND_OT    = 3'd3;
   localparam logic [2:0] KIND_ACK   = 3'd4;

   localparam logic [2:0] MODE_DEV_WORDS  = 3'd0;
   localparam logic [2:0] MODE_RAM_BLOCKS = 3'd1;
   localparam logic [2:0] MODE_DEV_BLOCKS = 3'd2;
   localparam logic [2:0] MODE_LIST       = 3'd3;
   localparam logic [2:0] MODE_OT_CLEAR   = 3'd4;

   localparam logic [1:0] ACT_READ  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_DEV   = 2'd2;
   localparam logic [1:0] ACT_DONE  = 2'd3;

   localparam logic [2:0] REG_START = 3'd0;
   localparam logic [2:0] REG_WCNT  = 3'd1;
   localparam logic [2:0] REG_BCNT  = 3'd2;
   localparam logic [2:0] REG_BACK  = 3'd3;
   localparam logic [2:0] REG_MODE  = 3'd4;
   localparam logic [2:0] REG_IEN   = 3'd5;
   localparam logic [2:0] REG_MIEN  = 3'd6;
   localparam logic [2:0] REG_FORCE = 3'd7;

   localparam logic [31:0] READ_MASK = 32'h001f_fffc;
   localparam logic [23:0] LINK_END  = 24'hff_ffff;
   localparam logic [23:0] LINK_MASK = 24'h1f_ffff;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] address;
      logic [31:0] word;
   } res_type;

   typedef struct packed {
      logic    [1:0] count;
      res_type       r0;
      res_type       r1;
      logic          busy;
      logic          flag;
      logic          master;
   } entry_type;
endpackage

// File: rtl/dcs_front.sv
// Front part: register file, channel state and per-item classification.
// Depends on dcs_pkg.
module dcs_front #(
   parameter int MAX_PACKETS = dcs_pkg::MaxPackets
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [23:0]         csr_data,
   input  logic                take,
   input  logic [2:0]          kind,
   input  logic [31:0]         data,
   output dcs_pkg::entry_type  entry
);
   logic [23:0] start_ff;
   logic [15:0] wcnt_ff, bcnt_ff;
   logic        back_ff, ien_ff, mien_ff, force_ff;
   logic [2:0]  mode_ff;
   logic        busy_ff, busy_in;
   logic [31:0] addr_ff, addr_in, left_ff, left_in;
   logic [7:0]  pleft_ff, pleft_in, pidx_ff, pidx_in;
   logic [23:0] link_ff, link_in;
   logic        hdr_ff, hdr_in, flag_ff, flag_in;
   logic [15:0] pcnt_ff, pcnt_in;
   dcs_pkg::entry_type e;
   logic [31:0] stepv, wtot, paddr;
   logic [7:0]  nidx, nleft;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0; wcnt_ff <= '0; bcnt_ff <= '0; back_ff <= 1'b0;
         mode_ff <= '0; ien_ff <= 1'b0; mien_ff <= 1'b0; force_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            dcs_pkg::REG_START: start_ff <= csr_data;
            dcs_pkg::REG_WCNT:  wcnt_ff <= csr_data[15:0];
            dcs_pkg::REG_BCNT:  bcnt_ff <= csr_data[15:0];
            dcs_pkg::REG_BACK:  back_ff <= csr_data[0];
            dcs_pkg::REG_MODE:  mode_ff <= csr_data[2:0];
            dcs_pkg::REG_IEN:   ien_ff <= csr_data[0];
            dcs_pkg::REG_MIEN:  mien_ff <= csr_data[0];
            dcs_pkg::REG_FORCE: force_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      busy_in = busy_ff; addr_in = addr_ff; left_in = left_ff;
      pleft_in = pleft_ff; pidx_in = pidx_ff; link_in = link_ff;
      hdr_in = hdr_ff; pcnt_in = pcnt_ff; flag_in = flag_ff;
      e = '0;
      stepv = back_ff ? 32'hffff_fffc : 32'd4;
      wtot = (mode_ff == dcs_pkg::MODE_DEV_WORDS || mode_ff == dcs_pkg::MODE_OT_CLEAR)
             ? {16'd0, wcnt_ff} : ({16'd0, wcnt_ff} * {16'd0, bcnt_ff});
      nidx = 8'd0; nleft = 8'd0; paddr = '0;
      if (take) begin
         case (kind) inside
            dcs_pkg::KIND_START: begin
               if (!busy_ff && mode_ff <= dcs_pkg::MODE_OT_CLEAR) begin
                  addr_in = {8'd0, start_ff};
                  if (mode_ff == dcs_pkg::MODE_LIST) begin
                     busy_in = 1'b1; hdr_in = 1'b1; pcnt_in = '0;
                     pleft_in = '0; pidx_in = '0;
                     e.count = 2'd1;
                     e.r0.address = {8'd0, start_ff} & dcs_pkg::READ_MASK;
                  end else begin
                     left_in = wtot;
                     if (wtot == '0) begin
                        if (ien_ff) flag_in = 1'b1;
                        e.count = 2'd1; e.r0.action = dcs_pkg::ACT_DONE;
                     end else begin
                        busy_in = 1'b1;
                        if (mode_ff == dcs_pkg::MODE_RAM_BLOCKS) begin
                           e.count = 2'd1;
                           e.r0.address = {8'd0, start_ff} & dcs_pkg::READ_MASK;
                        end
                     end
                  end
               end
            end
            dcs_pkg::KIND_MEM: begin
               if (busy_ff && mode_ff == dcs_pkg::MODE_RAM_BLOCKS) begin
                  e.count = 2'd2;
                  e.r0.action = dcs_pkg::ACT_DEV; e.r0.word = data;
                  addr_in = addr_ff + stepv;
                  left_in = left_ff - 32'd1;
                  if (left_in == '0) begin
                     busy_in = 1'b0; if (ien_ff) flag_in = 1'b1;
                     e.r1.action = dcs_pkg::ACT_DONE;
                  end else begin
                     e.r1.address = addr_in & dcs_pkg::READ_MASK;
                  end
               end else if (busy_ff && mode_ff == dcs_pkg::MODE_LIST) begin
                  if (hdr_ff) begin
                     nleft = data[31:24];
                     link_in = data[23:0];
                     pidx_in = '0;
                     nidx = 8'd0;
                     pleft_in = nleft;
                     e.count = 2'd1;
                     if (nleft != '0) hdr_in = 1'b0;
                  end else begin
                     e.count = 2'd2;
                     e.r0.action = dcs_pkg::ACT_DEV; e.r0.word = data;
                     nidx = pidx_ff + 8'd1;
                     nleft = pleft_ff - 8'd1;
                     pidx_in = nidx; pleft_in = nleft;
                  end
                  if (nleft != '0) begin
                     paddr = addr_ff + {22'd0, nidx + 8'd1, 2'b00};
                     if (hdr_ff) e.r0.address = paddr & dcs_pkg::READ_MASK;
                     else e.r1.address = paddr & dcs_pkg::READ_MASK;
                  end else begin
                     // packet done: follow link or finish
                     if (link_in == dcs_pkg::LINK_END ||
                         {16'd0, pcnt_ff} > 32'(MAX_PACKETS)) begin
                        busy_in = 1'b0; if (ien_ff) flag_in = 1'b1;
                        if (hdr_ff) e.r0.action = dcs_pkg::ACT_DONE;
                        else e.r1.action = dcs_pkg::ACT_DONE;
                     end else begin
                        hdr_in = 1'b1;
                        if (hdr_ff) e.r0.address = {11'd0, link_in[20:2], 2'b00};
                        else e.r1.address = {11'd0, link_in[20:2], 2'b00};
                     end
                     if (link_in != dcs_pkg::LINK_END) begin
                        addr_in = {8'd0, link_in & dcs_pkg::LINK_MASK};
                        if (pcnt_ff != 16'hffff) pcnt_in = pcnt_ff + 16'd1;
                     end
                  end
               end
            end
            dcs_pkg::KIND_DEV, dcs_pkg::KIND_OT: begin
               if (busy_ff && ((kind == dcs_pkg::KIND_DEV &&
                   (mode_ff == dcs_pkg::MODE_DEV_WORDS ||
                    mode_ff == dcs_pkg::MODE_DEV_BLOCKS))
                   || (kind == dcs_pkg::KIND_OT && mode_ff == dcs_pkg::MODE_OT_CLEAR))) begin
                  e.count = 2'd1;
                  e.r0.action = dcs_pkg::ACT_WRITE;
                  e.r0.address = addr_ff;
                  if (kind == dcs_pkg::KIND_DEV) e.r0.word = data;
                  else if (left_ff == 32'd1) e.r0.word = 32'h00ff_ffff;
                  else e.r0.word = (addr_ff + stepv) & 32'h001f_ffff;
                  addr_in = addr_ff + stepv;
                  left_in = left_ff - 32'd1;
                  if (left_in == '0) begin
                     busy_in = 1'b0; if (ien_ff) flag_in = 1'b1;
                     e.count = 2'd2;
                     e.r1.action = dcs_pkg::ACT_DONE;
                  end
               end
            end
            dcs_pkg::KIND_ACK: if (data[0]) flag_in = 1'b0;
            default: ;
         endcase
      end
      e.busy = busy_in;
      e.flag = flag_in;
      e.master = force_ff | (mien_ff & ien_ff & flag_in);
      entry = e;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; addr_ff <= '0; left_ff <= '0; pleft_ff <= '0;
         pidx_ff <= '0; link_ff <= '0; hdr_ff <= 1'b0; pcnt_ff <= '0;
         flag_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; addr_ff <= addr_in; left_ff <= left_in;
         pleft_ff <= pleft_in; pidx_ff <= pidx_in; link_ff <= link_in;
         hdr_ff <= hdr_in; pcnt_ff <= pcnt_in; flag_ff <= flag_in;
      end
   end
endmodule

// File: rtl/dcs_queue.sv
// Short queue of classified entries between front and back.
// Depends on dcs_pkg.
`include "dma_channel_sequencer_defines.svh"
module dcs_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  dcs_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               nonempty,
   output dcs_pkg::entry_type head
);
   dcs_pkg::entry_type mem_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;

   assign full = cnt_ff == 3'd4;
   assign nonempty = cnt_ff != 3'd0;
   assign head = mem_ff[rp_ff];

   always_ff @(posedge clock) if (push) mem_ff[wp_ff] <= push_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 2'd1;
         if (pop) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + {2'd0, push} - {2'd0, pop};
      end
   end

   `DCS_ASSERT(a_no_overflow, clock, reset, full |-> !push, "push into full queue")
   `DCS_ASSERT(a_no_underflow, clock, reset, !nonempty |-> !pop, "pop from empty queue")
   `DCS_ASSERT(a_count_max, clock, reset, cnt_ff <= 3'd4, "queue count out of range")
endmodule

// File: rtl/dcs_back.sv
// Back part: plays out zero, one or two transfers per entry onto the response port.
// Depends on dcs_pkg.
module dcs_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               nonempty,
   input  dcs_pkg::entry_type head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_action,
   output logic [31:0]        rsp_address,
   output logic [31:0]        rsp_word,
   output logic               rsp_last,
   output logic               rsp_busy_res,
   output logic               rsp_irq_flag,
   output logic               rsp_master_irq
);
   logic sec_ff;
   logic two;
   dcs_pkg::res_type r;

   assign two = head.count == 2'd2;
   assign rsp_valid = nonempty && head.count != 2'd0;
   assign r = sec_ff ? head.r1 : head.r0;
   assign rsp_action = r.action;
   assign rsp_address = r.address;
   assign rsp_word = r.word;
   assign rsp_last = !two || sec_ff;
   assign rsp_busy_res = head.busy;
   assign rsp_irq_flag = head.flag;
   assign rsp_master_irq = head.master;
   assign pop = nonempty && (head.count == 2'd0 || (!rsp_stall && rsp_last));

   always_ff @(posedge clock) begin
      if (reset) sec_ff <= 1'b0;
      else if (rsp_valid && !rsp_stall) sec_ff <= two && !sec_ff;
   end
endmodule

// File: rtl/dma_channel_sequencer.sv
// One DMA channel with five transfer modes, handled by items.
// req_ carries items (kind, data), rsp_ carries transfers (action, address,
// word, last, status). csr_ writes one register per cycle; the user must
// write only while idle, which the block does not enforce. An accepted item
// is classified in the cycle it arrives and produces zero, one or two
// transfers. Throughput is one item per cycle while rsp_stall is low and
// items yield at most one transfer; an item with two transfers holds the
// output port for both. A four-entry queue between classifier and output
// lets req_ keep flowing while rsp_stall is high until the queue fills, then
// req_stall rises. Items that yield no transfer still pass through the queue
// in order. Reset clears all registers, channel state and the queue.
// An item accepted along with a register write still sees the old value.
module dma_channel_sequencer #(
   parameter int MAX_PACKETS = dcs_pkg::MaxPackets
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [31:0] req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_action,
   output logic [31:0] rsp_address,
   output logic [31:0] rsp_word,
   output logic        rsp_last,
   output logic        rsp_busy_res,
   output logic        rsp_irq_flag,
   output logic        rsp_master_irq
);
   dcs_pkg::entry_type ent, head;
   logic take, full, nonempty, pop;

   assign req_stall = full;
   assign take = req_valid && !full;

   dcs_front #(.MAX_PACKETS(MAX_PACKETS)) u_front (
      .clock, .reset, .csr_write, .csr_index, .csr_data,
      .take, .kind(req_kind), .data(req_data), .entry(ent)
   );

   dcs_queue u_queue (
      .clock, .reset, .push(take), .push_entry(ent), .full,
      .pop, .nonempty, .head
   );

   dcs_back u_back (
      .clock, .reset, .nonempty, .head, .pop,
      .rsp_valid, .rsp_stall, .rsp_action, .rsp_address, .rsp_word,
      .rsp_last, .rsp_busy_res, .rsp_irq_flag, .rsp_master_irq
   );
endmodule

// File: sim/dma_channel_sequencer_tb.sv
// Testbench for dma_channel_sequencer: scoreboard class with its own channel predictor,
// plain tasks for the item and register ports. Depends on dcs_pkg and the RTL.
`timescale 1ns / 100ps

module dma_channel_sequencer_tb;

   typedef struct packed {
      bit [1:0]  act;
      bit [31:0] addr;
      bit [31:0] word;
      bit        last;
      bit        busy;
      bit        flag;
      bit        master;
   } xfer_type;

   class dma_scoreboard;
      xfer_type  pending[$];
      xfer_type  staged[$];
      int        errors;
      bit [23:0] base_addr;
      bit [15:0] wcount, bcount;
      bit        step_back, ien, mien, force_irq;
      bit [2:0]  mode;
      bit        busy, flag, hdr_phase;
      bit [31:0] cur_addr, words_left;
      bit [7:0]  pkt_left, pkt_index;
      bit [23:0] next_link;
      bit [15:0] pkt_count;

      function new();
         errors = 0;
      endfunction

      function void set_reg(bit [2:0] idx, bit [23:0] v);
         case (idx)
            dcs_pkg::REG_START: base_addr = v;
            dcs_pkg::REG_WCNT:  wcount = v[15:0];
            dcs_pkg::REG_BCNT:  bcount = v[15:0];
            dcs_pkg::REG_BACK:  step_back = v[0];
            dcs_pkg::REG_MODE:  mode = v[2:0];
            dcs_pkg::REG_IEN:   ien = v[0];
            dcs_pkg::REG_MIEN:  mien = v[0];
            dcs_pkg::REG_FORCE: force_irq = v[0];
            default: ;
         endcase
      endfunction

      function void add(bit [1:0] a, bit [31:0] ad, bit [31:0] w);
         xfer_type x;
         x = '0;
         x.act = a; x.addr = ad; x.word = w;
         if (staged.size() < 2) staged.push_back(x);
      endfunction

      function bit [31:0] stride();
         return step_back ? 32'hffff_fffc : 32'd4;
      endfunction

      function void complete();
         busy = 0;
         if (ien) flag = 1;
         add(dcs_pkg::ACT_DONE, 0, 0);
      endfunction

      function void payload_read();
         add(dcs_pkg::ACT_READ,
             (cur_addr + 32'd4 * ({24'd0, pkt_index} + 1)) & dcs_pkg::READ_MASK, 0);
      endfunction

      function void next_packet();
         bit [15:0] old;
         if (next_link == dcs_pkg::LINK_END) begin
            complete();
            return;
         end
         cur_addr = {8'd0, next_link & dcs_pkg::LINK_MASK};
         old = pkt_count;
         if (pkt_count < 16'hffff) pkt_count++;
         if (old > dcs_pkg::MaxPackets) begin
            complete();
            return;
         end
         hdr_phase = 1;
         add(dcs_pkg::ACT_READ, cur_addr & dcs_pkg::READ_MASK, 0);
      endfunction

      function void write_word(bit [31:0] d);
         add(dcs_pkg::ACT_WRITE, cur_addr, d);
         cur_addr += stride();
         words_left--;
         if (words_left == 0) complete();
      endfunction

      function void note_input(bit [2:0] kind, bit [31:0] data);
         bit m;
         staged.delete();
         case (kind)
            dcs_pkg::KIND_START: if (!busy && mode <= dcs_pkg::MODE_OT_CLEAR) begin
               cur_addr = {8'd0, base_addr};
               if (mode == dcs_pkg::MODE_LIST) begin
                  busy = 1; hdr_phase = 1; pkt_count = 0; pkt_left = 0; pkt_index = 0;
                  add(dcs_pkg::ACT_READ, cur_addr & dcs_pkg::READ_MASK, 0);
               end else begin
                  if (mode == dcs_pkg::MODE_DEV_WORDS || mode == dcs_pkg::MODE_OT_CLEAR)
                     words_left = {16'd0, wcount};
                  else
                     words_left = {16'd0, wcount} * {16'd0, bcount};
                  if (words_left == 0) complete();
                  else begin
                     busy = 1;
                     if (mode == dcs_pkg::MODE_RAM_BLOCKS)
                        add(dcs_pkg::ACT_READ, cur_addr & dcs_pkg::READ_MASK, 0);
                  end
               end
            end
            dcs_pkg::KIND_MEM: if (busy) begin
               if (mode == dcs_pkg::MODE_RAM_BLOCKS) begin
                  add(dcs_pkg::ACT_DEV, 0, data);
                  cur_addr += stride();
                  words_left--;
                  if (words_left == 0) complete();
                  else add(dcs_pkg::ACT_READ, cur_addr & dcs_pkg::READ_MASK, 0);
               end else if (mode == dcs_pkg::MODE_LIST) begin
                  if (hdr_phase) begin
                     pkt_left = data[31:24];
                     next_link = data[23:0];
                     pkt_index = 0;
                     if (pkt_left != 0) begin
                        hdr_phase = 0;
                        payload_read();
                     end else next_packet();
                  end else begin
                     add(dcs_pkg::ACT_DEV, 0, data);
                     pkt_index++;
                     pkt_left--;
                     if (pkt_left != 0) payload_read();
                     else next_packet();
                  end
               end
            end
            dcs_pkg::KIND_DEV:
               if (busy && (mode == dcs_pkg::MODE_DEV_WORDS ||
                            mode == dcs_pkg::MODE_DEV_BLOCKS))
                  write_word(data);
            dcs_pkg::KIND_OT:
               if (busy && mode == dcs_pkg::MODE_OT_CLEAR)
                  write_word(words_left == 1 ? {8'd0, dcs_pkg::LINK_END}
                             : (cur_addr + stride()) & {8'd0, dcs_pkg::LINK_MASK});
            dcs_pkg::KIND_ACK: if (data[0]) flag = 0;
            default: ;
         endcase
         m = force_irq | (mien & ien & flag);
         foreach (staged[i]) begin
            staged[i].last = (i == staged.size() - 1);
            staged[i].busy = busy;
            staged[i].flag = flag;
            staged[i].master = m;
            pending.push_back(staged[i]);
         end
      endfunction

      function void check_result(xfer_type got);
         xfer_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected transfer: action %0d addr %h word %h",
                                       got.act, got.addr, got.word);
            return;
         end
         want = pending.pop_front();
         if (want != got) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: exp %0d %h %h %b%b%b%b got %0d %h %h %b%b%b%b",
                        want.act, want.addr, want.word, want.last, want.busy, want.flag,
                        want.master, got.act, got.addr, got.word, got.last, got.busy,
                        got.flag, got.master);
         end
      endfunction
   endclass

   logic        clock = 0, reset = 1;
   logic        csr_write = 0;
   logic [2:0]  csr_index = 0;
   logic [23:0] csr_data = 0;
   logic        req_valid = 0;
   logic        req_stall;
   logic [2:0]  req_kind = 0;
   logic [31:0] req_data = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [1:0]  rsp_action;
   logic [31:0] rsp_address, rsp_word;
   logic        rsp_last, rsp_busy_res, rsp_irq_flag, rsp_master_irq;

   dma_channel_sequencer uut (.*);

   dma_scoreboard sb = new();
   int tx_idle_pct = 26, rx_idle_pct = 63;
   int items = 0;
   int cycles = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 400000) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(negedge clock) rsp_stall = ($urandom_range(99) < rx_idle_pct);

   always @(posedge clock) begin
      xfer_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.act = rsp_action; got.addr = rsp_address; got.word = rsp_word;
         got.last = rsp_last; got.busy = rsp_busy_res; got.flag = rsp_irq_flag;
         got.master = rsp_master_irq;
         sb.check_result(got);
      end
   end

   task automatic write_reg(bit [2:0] idx, bit [23:0] v);
      csr_write = 1; csr_index = idx; csr_data = v;
      sb.set_reg(idx, v);
      @(negedge clock);
      csr_write = 0;
   endtask

   task automatic send_item(bit [2:0] kind, bit [31:0] data);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid = 1; req_kind = kind; req_data = data;
      do @(posedge clock); while (req_stall);
      sb.note_input(kind, data);
      items++;
      if (items == 200) begin tx_idle_pct = 63; rx_idle_pct = 26; end
      if (items == 400) begin tx_idle_pct = 0; rx_idle_pct = 0; end
      @(negedge clock);
      req_valid = 0;
   endtask

   // hold until every transfer is in, then let the queue empty of silent items
   task automatic drain();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic configure(bit [23:0] sa, bit [15:0] wc, bit [15:0] bc, bit [2:0] md);
      drain();
      write_reg(dcs_pkg::REG_START, sa);
      write_reg(dcs_pkg::REG_WCNT, wc);
      write_reg(dcs_pkg::REG_BCNT, bc);
      write_reg(dcs_pkg::REG_BACK, $urandom_range(1));
      write_reg(dcs_pkg::REG_MODE, md);
      write_reg(dcs_pkg::REG_IEN, $urandom_range(1));
      write_reg(dcs_pkg::REG_MIEN, $urandom_range(1));
      write_reg(dcs_pkg::REG_FORCE, $urandom_range(1));
      repeat (3) @(negedge clock);
   endtask

   task automatic send_next();
      bit [31:0] d = $urandom;
      if ($urandom_range(99) < 8) begin
         send_item($urandom_range(7), d);
      end else if (!sb.busy) begin
         if ($urandom_range(3) == 0) send_item(dcs_pkg::KIND_ACK, d);
         else send_item(dcs_pkg::KIND_START, d);
      end else case (sb.mode) inside
         dcs_pkg::MODE_DEV_WORDS, dcs_pkg::MODE_DEV_BLOCKS: send_item(dcs_pkg::KIND_DEV, d);
         dcs_pkg::MODE_OT_CLEAR: send_item(dcs_pkg::KIND_OT, d);
         dcs_pkg::MODE_RAM_BLOCKS: send_item(dcs_pkg::KIND_MEM, d);
         default: begin
            if (sb.hdr_phase) begin
               d[31:24] = $urandom_range(3);
               if ($urandom_range(3) == 0) d[23:0] = dcs_pkg::LINK_END;
            end
            send_item(dcs_pkg::KIND_MEM, d);
         end
      endcase
   endtask

   task automatic run_transfer(int min_items);
      int n = 0;
      send_item(dcs_pkg::KIND_START, $urandom);
      while ((sb.busy || n < min_items) && n < 300) begin
         send_next();
         n++;
      end
   endtask

   initial begin
      bit [2:0]  md;
      bit [15:0] wc, bc;
      bit [23:0] sa;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      configure(24'hff_ffff, 16'd0, 16'hffff, dcs_pkg::MODE_DEV_WORDS);
      send_item(dcs_pkg::KIND_MEM, 32'hffff_ffff);
      send_item(dcs_pkg::KIND_DEV, 32'h0);
      send_item(dcs_pkg::KIND_OT, 32'h1234_5678);
      send_item(dcs_pkg::KIND_START, 0);
      send_item(3'd5, 32'hffff_ffff);
      send_item(3'd7, 0);
      send_item(dcs_pkg::KIND_ACK, 32'hffff_fffe);
      send_item(dcs_pkg::KIND_ACK, 32'h1);
      configure(24'h0, 16'hffff, 16'd0, dcs_pkg::MODE_DEV_BLOCKS);
      send_item(dcs_pkg::KIND_START, 0);
      configure(24'h0, 16'd2, 16'd2, 3'd5);
      send_item(dcs_pkg::KIND_START, 0);
      send_item(dcs_pkg::KIND_DEV, 0);
      configure(24'h0, 16'd0, 16'd65535, 3'd7);
      send_item(dcs_pkg::KIND_START, 0);
      configure(24'hff_fffc, 16'd3, 16'd2, dcs_pkg::MODE_OT_CLEAR);
      run_transfer(0);
      configure(24'h00_0000, 16'd2, 16'd2, dcs_pkg::MODE_LIST);
      send_item(dcs_pkg::KIND_START, 0);
      send_item(dcs_pkg::KIND_MEM, 32'h0000_0010);
      send_item(dcs_pkg::KIND_MEM, 32'h02ff_ffff);
      send_item(dcs_pkg::KIND_MEM, 32'hffff_ffff);
      send_item(dcs_pkg::KIND_MEM, 32'h0000_0000);

      while (items < 600) begin
         md = $urandom_range(4);
         sa = $urandom;
         case ($urandom_range(5))
            0: sa = 24'hff_ffff;
            1: sa = 24'h0;
            default: ;
         endcase
         wc = (md == dcs_pkg::MODE_RAM_BLOCKS || md == dcs_pkg::MODE_DEV_BLOCKS)
              ? $urandom_range(4) : $urandom_range(8);
         bc = $urandom_range(4);
         configure(sa, wc, bc, md);
         run_transfer($urandom_range(4));
      end

      drain();
      repeat (20) @(negedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
